/* rtl/core/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Screen geometry, character and register codes, and the command/status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int MARGIN  = 1;
    localparam int CELLS   = COLUMNS * ROWS;

    // Port field widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int X_W     = 7;
    localparam int Y_W     = 5;
    localparam int IDX_W   = 11;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = CHAR_W + COLOR_W;

    // Internal widths
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CUR_W   = $clog2(CELLS + COLUMNS + MARGIN + 1);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS + 1);
    localparam int SW_W    = $clog2(CELLS + 1);
    localparam int SET_W   = $clog2((2**Y_W - 1) * COLUMNS + 2**X_W + MARGIN + 1);

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EOF_CODE   = 1'd1;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SETCUR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0]  BLANK_CHAR     = 8'h20;
    localparam logic [CHAR_W-1:0]  CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  EOF_RESET      = 8'hFF;
    localparam logic [COLOR_W-1:0] RESET_COLOR    = 8'h07;

    typedef enum logic [1:0] {
        SWEEP_NONE,
        SWEEP_INIT,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } sweep_t;

    typedef enum logic [3:0] {
        CUR_HOLD,
        CUR_ADV,
        CUR_BACK,
        CUR_NEWLINE,
        CUR_SCROLL_HOME,
        CUR_HOME,
        CUR_SET,
        CUR_NORM_STEP,
        CUR_NORM_END
    } cur_op_t;

    typedef struct packed {
        logic    load_in;
        cur_op_t cur_op;
        logic    wr_char;
        logic    wr_bs;
        sweep_t  sweep;
        logic    rd_cell;
        logic    out_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              past_end;
        logic              is_newline;
        logic              is_backspace;
        logic              is_eof;
        logic              bs_ok;
        logic              at_last_col;
        logic              sweep_done;
        logic              norm_done;
        logic              out_free;
    } tcw_status_t;

endpackage
`default_nettype wire

/* rtl/core/tcw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: text console writer controller
// Sequences each request through the datapath: put-char decisions, scroll
// and clear sweeps, cursor normalization, cell reads and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire tcw_pkg::tcw_status_t st,
    output tcw_pkg::tcw_cmd_t         cmd
);
    import tcw_pkg::*;

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EXEC    = 4'd2;
    localparam logic [3:0] S_SCROLL  = 4'd3;
    localparam logic [3:0] S_NLFIX   = 4'd4;
    localparam logic [3:0] S_WRAPFIX = 4'd5;
    localparam logic [3:0] S_WRITE   = 4'd6;
    localparam logic [3:0] S_CLEAR   = 4'd7;
    localparam logic [3:0] S_NORM    = 4'd8;
    localparam logic [3:0] S_READ    = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] ret_reg;
    logic [3:0] ret_next;
    logic       finish;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        finish       = 1'b0;
        cmd          = '0;
        cmd.cur_op   = CUR_HOLD;
        cmd.sweep    = SWEEP_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep = SWEEP_INIT;
                if (st.sweep_done)
                begin
                    cmd.cur_op = CUR_HOME;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (st.func)
                    FUNC_PUT:
                    begin
                        // A cursor left past the end scrolls before anything else.
                        priority if (st.past_end)
                        begin
                            ret_next   = S_EXEC;
                            state_next = S_SCROLL;
                        end
                        else if (st.is_newline)
                        begin
                            cmd.cur_op = CUR_NEWLINE;
                            state_next = S_NLFIX;
                        end
                        else if (st.is_backspace)
                        begin
                            if (st.bs_ok)
                            begin
                                cmd.wr_bs  = 1'b1;
                                cmd.cur_op = CUR_BACK;
                            end
                            finish = 1'b1;
                        end
                        else if (st.is_eof)
                        begin
                            finish = 1'b1;
                        end
                        else if (st.at_last_col)
                        begin
                            cmd.cur_op = CUR_NEWLINE;
                            state_next = S_WRAPFIX;
                        end
                        else
                        begin
                            cmd.wr_char = 1'b1;
                            cmd.cur_op  = CUR_ADV;
                            finish      = 1'b1;
                        end
                    end
                    FUNC_SETCUR:
                    begin
                        cmd.cur_op = CUR_SET;
                        state_next = S_NORM;
                    end
                    FUNC_CLEAR:
                    begin
                        state_next = S_CLEAR;
                    end
                    FUNC_READ:
                    begin
                        cmd.rd_cell = 1'b1;
                        state_next  = S_READ;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_SCROLL:
            begin
                cmd.sweep = SWEEP_SCROLL;
                if (st.sweep_done)
                begin
                    cmd.cur_op = CUR_SCROLL_HOME;
                    state_next = ret_reg;
                end
            end
            S_NLFIX:
            begin
                if (st.past_end)
                begin
                    ret_next   = S_DONE;
                    state_next = S_SCROLL;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            S_WRAPFIX:
            begin
                if (st.past_end)
                begin
                    ret_next   = S_WRITE;
                    state_next = S_SCROLL;
                end
                else
                begin
                    cmd.wr_char = 1'b1;
                    cmd.cur_op  = CUR_ADV;
                    finish      = 1'b1;
                end
            end
            S_WRITE:
            begin
                cmd.wr_char = 1'b1;
                cmd.cur_op  = CUR_ADV;
                finish      = 1'b1;
            end
            S_CLEAR:
            begin
                cmd.sweep = SWEEP_CLEAR;
                if (st.sweep_done)
                begin
                    cmd.cur_op = CUR_HOME;
                    finish     = 1'b1;
                end
            end
            S_NORM:
            begin
                if (st.norm_done)
                begin
                    cmd.cur_op = CUR_NORM_END;
                    finish     = 1'b1;
                end
                else
                begin
                    cmd.cur_op = CUR_NORM_STEP;
                end
            end
            S_READ:
            begin
                finish = 1'b1;
            end
            S_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The result goes straight to the output register when it is free.
        if (finish)
        begin
            if (st.out_free)
            begin
                cmd.out_load = 1'b1;
                state_next   = S_IDLE;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ret_reg   <= S_DONE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/tcw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: text console writer datapath
// Holds the screen memory, cursor, configuration registers, sweep counter
// and output register, and carries out the controller's commands.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tcw_pkg::tcw_cmd_t             cmd,
    output tcw_pkg::tcw_status_t               st,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
    input  wire logic [tcw_pkg::FUNC_W-1:0]    func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tcw_pkg::X_W-1:0]       col_x,
    input  wire logic [tcw_pkg::Y_W-1:0]       row_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [tcw_pkg::CHAR_W-1:0]         cell_char,
    output logic [tcw_pkg::COLOR_W-1:0]        cell_color,
    output logic [tcw_pkg::IDX_W-1:0]          cursor_index
);
    import tcw_pkg::*;

    // Request latch
    logic [FUNC_W-1:0]  func_reg;
    logic [CHAR_W-1:0]  code_reg;
    logic [X_W-1:0]     x_reg;
    logic [Y_W-1:0]     y_reg;

    // Configuration
    logic [COLOR_W-1:0] color_reg;
    logic [CHAR_W-1:0]  eof_reg;

    // Cursor
    logic [CUR_W-1:0]   cur_reg;
    logic [CUR_W-1:0]   cur_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [CUR_W-1:0]   rem_reg;
    logic [CUR_W-1:0]   rem_next;

    // Sweep counter
    logic [SW_W-1:0]    sw_reg;
    logic [SW_W-1:0]    sw_next;
    logic               sweep_on;
    logic               sweep_wr;
    logic               sweep_rd;
    logic               move_phase;

    // Memory
    logic [CELL_W-1:0]  mem [CELLS];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [CELL_W-1:0]  rd_data_reg;
    logic               rd_hit_reg;

    // Address arithmetic
    logic [SET_W-1:0]   set_pos;
    logic [CUR_W-1:0]   set_sat;
    logic [SET_W-1:0]   cell_pos;
    logic               on_screen;
    logic [COLOR_W-1:0] blank_color;

    // Output register
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  cell_char_reg;
    logic [COLOR_W-1:0] cell_color_reg;
    logic [IDX_W-1:0]   cursor_index_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            code_reg <= char_code;
            x_reg    <= col_x;
            y_reg    <= row_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= RESET_COLOR;
            eof_reg   <= EOF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TEXT_COLOR)
            begin
                color_reg <= cfg_data;
            end
            else if (cfg_index == REG_EOF_CODE)
            begin
                eof_reg <= cfg_data;
            end
        end
    end

    // Set-cursor index saturates at the past-end position.
    assign set_pos   = SET_W'(y_reg) * SET_W'(COLUMNS) + SET_W'(x_reg) + SET_W'(MARGIN);
    assign set_sat   = (set_pos > SET_W'(CELLS)) ? CUR_W'(CELLS) : CUR_W'(set_pos);
    assign cell_pos  = SET_W'(y_reg) * SET_W'(COLUMNS) + SET_W'(x_reg);
    assign on_screen = (SET_W'(x_reg) < SET_W'(COLUMNS)) && (SET_W'(y_reg) < SET_W'(ROWS));

    always_comb
    begin
        cur_next = cur_reg;
        row_next = row_reg;
        col_next = col_reg;
        rem_next = rem_reg;
        unique case (cmd.cur_op)
            CUR_HOLD:
            begin
                cur_next = cur_reg;
            end
            CUR_ADV:
            begin
                cur_next = cur_reg + CUR_W'(1);
                col_next = col_reg + COL_W'(1);
            end
            CUR_BACK:
            begin
                cur_next = cur_reg - CUR_W'(1);
                col_next = col_reg - COL_W'(1);
            end
            CUR_NEWLINE:
            begin
                cur_next = cur_reg - CUR_W'(col_reg) + CUR_W'(COLUMNS + MARGIN);
                row_next = row_reg + ROW_W'(1);
                col_next = COL_W'(MARGIN);
            end
            CUR_SCROLL_HOME:
            begin
                cur_next = CUR_W'((ROWS - 1) * COLUMNS + MARGIN);
                row_next = ROW_W'(ROWS - 1);
                col_next = COL_W'(MARGIN);
            end
            CUR_HOME:
            begin
                cur_next = CUR_W'(MARGIN);
                row_next = '0;
                col_next = COL_W'(MARGIN);
            end
            CUR_SET:
            begin
                cur_next = set_sat;
                rem_next = set_sat;
                row_next = '0;
            end
            CUR_NORM_STEP:
            begin
                rem_next = rem_reg - CUR_W'(COLUMNS);
                row_next = row_reg + ROW_W'(1);
            end
            CUR_NORM_END:
            begin
                col_next = COL_W'(rem_reg);
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= CUR_W'(MARGIN);
            row_reg <= '0;
            col_reg <= COL_W'(MARGIN);
            rem_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
            row_reg <= row_next;
            col_reg <= col_next;
            rem_reg <= rem_next;
        end
    end

    // Sweeps write cell sw-1 at count sw, so the count runs 0 to CELLS and
    // returns to zero as the sweep ends.
    // A scroll reads one row ahead and writes the word its previous read left in rd_data_reg.
    assign sweep_on   = (cmd.sweep != SWEEP_NONE);
    assign sw_next    = (sweep_on && (sw_reg != SW_W'(CELLS))) ? sw_reg + SW_W'(1) : '0;
    assign sweep_wr   = sweep_on && (sw_reg != '0);
    assign move_phase = (cmd.sweep == SWEEP_SCROLL) && (sw_reg <= SW_W'(CELLS - COLUMNS));
    assign sweep_rd   = (cmd.sweep == SWEEP_SCROLL) && (sw_reg < SW_W'(CELLS - COLUMNS));
    assign blank_color = (cmd.sweep == SWEEP_INIT) ? RESET_COLOR : color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= '0;
        end
        else
        begin
            sw_reg <= sw_next;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(cur_reg);
        mem_wdata = {code_reg, color_reg};
        priority if (sweep_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(sw_reg - SW_W'(1));
            mem_wdata = move_phase ? rd_data_reg : {BLANK_CHAR, blank_color};
        end
        else if (cmd.wr_char)
        begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(cur_reg);
            mem_wdata = {code_reg, color_reg};
        end
        else if (cmd.wr_bs)
        begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(cur_reg - CUR_W'(1));
            mem_wdata = {BLANK_CHAR, color_reg};
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    assign mem_re    = sweep_rd || (cmd.rd_cell && on_screen);
    assign mem_raddr = sweep_rd ? ADDR_W'(sw_reg + SW_W'(COLUMNS)) : ADDR_W'(cell_pos);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hit_reg <= 1'b0;
        end
        else if (cmd.load_in)
        begin
            rd_hit_reg <= 1'b0;
        end
        else if (cmd.rd_cell)
        begin
            rd_hit_reg <= on_screen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cell_char_reg    <= rd_hit_reg ? rd_data_reg[CELL_W-1:COLOR_W] : '0;
            cell_color_reg   <= rd_hit_reg ? rd_data_reg[COLOR_W-1:0] : '0;
            cursor_index_reg <= IDX_W'(cur_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_char    = cell_char_reg;
    assign cell_color   = cell_color_reg;
    assign cursor_index = cursor_index_reg;

    always_comb
    begin
        st              = '0;
        st.func         = func_reg;
        st.past_end     = (cur_reg >= CUR_W'(CELLS));
        st.is_newline   = (code_reg == CODE_NEWLINE);
        st.is_backspace = (code_reg == CODE_BACKSPACE);
        st.is_eof       = (code_reg == eof_reg);
        st.bs_ok        = (col_reg > COL_W'(MARGIN)) && (cur_reg != '0);
        st.at_last_col  = (col_reg >= COL_W'(COLUMNS - 1));
        st.sweep_done   = (sw_reg == SW_W'(CELLS));
        st.norm_done    = (rem_reg < CUR_W'(COLUMNS));
        st.out_free     = !out_valid_reg || !out_stall;
    end

`ifndef SYNTH
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({sweep_wr, cmd.wr_char, cmd.wr_bs}))
        else $error("more than one screen write source in a cycle");

    a_char_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_char |-> (cur_reg < CUR_W'(CELLS)))
        else $error("character write with the cursor past the end");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS))
        else $error("cursor column out of range");

    a_accept_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |-> (sw_reg == '0) && !sweep_on)
        else $error("request accepted during a sweep");

    a_cursor_home_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep == SWEEP_CLEAR) && (sw_reg == SW_W'(CELLS)) |=>
            (cur_reg == CUR_W'(MARGIN)) && (row_reg == '0))
        else $error("cursor not home after clear");
`endif

endmodule
`default_nettype wire

/* rtl/core/text_console_writer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_core: text-mode console with scroll
// Keeps a screen of character/attribute cells and a cursor, and serves
// put-char, set-cursor, clear-screen and read-cell requests.
//
//   channel  direction  handshake             beat contents
//   in       input      in_valid / in_stall   func, char_code, col_x, row_y
//   out      output     out_valid / out_stall cell_char, cell_color, cursor_index
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A plain character is accepted and then written with one cell write;
// read-cell reads the memory before the result is loaded, and set-cursor
// runs a row search with one step per screen row of the target. Every
// scroll adds a full pass through the screen memory and a step to pick the
// request up again; clear-screen makes a full pass through the memory too.
// After reset a clearing pass blanks the screen before the first input beat
// is taken; configuration writes are taken at any time. A result held by
// out_stall does not block the next input beat.
// ----------------------------------------------------------------------------
module text_console_writer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tcw_pkg::FUNC_W-1:0]    func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tcw_pkg::X_W-1:0]       col_x,
    input  wire logic [tcw_pkg::Y_W-1:0]       row_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [tcw_pkg::CHAR_W-1:0]         cell_char,
    output logic [tcw_pkg::COLOR_W-1:0]        cell_color,
    output logic [tcw_pkg::IDX_W-1:0]          cursor_index,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t st;

    // Registers are plain flops, so a write can land in any cycle.
    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .char_code    (char_code),
        .col_x        (col_x),
        .row_y        (row_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_char    (cell_char),
        .cell_color   (cell_color),
        .cursor_index (cursor_index)
    );

endmodule
`default_nettype wire

/* tb/text_console_writer_core_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_core_test: self-checking bench for the text console
// Drives put-char, set-cursor, clear-screen and read-cell requests into the
// core. A behavioral copy of the screen and cursor predicts every result,
// and each result is compared field by field in arrival order. Directed
// cases cover the cursor edges, line wrap, scrolling and the ignored code.
// Random text lines with register changes between phases follow. Both sides
// idle at random, and one long hold on the result side backs up the input.
// ----------------------------------------------------------------------------
module text_console_writer_core_test;

    import tcw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 250;

    typedef struct packed {
        logic [CHAR_W-1:0]  glyph;
        logic [COLOR_W-1:0] attr;
        logic [IDX_W-1:0]   cursor;
    } console_reply_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func      = FUNC_PUT;
    logic [CHAR_W-1:0]    char_code = '0;
    logic [X_W-1:0]       col_x     = '0;
    logic [Y_W-1:0]       row_y     = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CHAR_W-1:0]    cell_char;
    logic [COLOR_W-1:0]   cell_color;
    logic [IDX_W-1:0]     cursor_index;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_TEXT_COLOR;
    logic [COLOR_W-1:0]   cfg_data  = '0;

    // Predicted screen, cursor and registers.
    logic [CHAR_W-1:0]  glyph_mem [CELLS];
    logic [COLOR_W-1:0] attr_mem [CELLS];
    int unsigned        cursor_at;
    logic [COLOR_W-1:0] color_reg;
    logic [CHAR_W-1:0]  eof_reg;

    console_reply_t pending_replies [$];
    int unsigned    requests_sent = 0;
    int unsigned    mismatches    = 0;
    int unsigned    hold_cycles   = 0;
    int unsigned    quiet_cycles  = 0;
    bit             sender_calm   = 1'b0;
    bit             receiver_calm = 1'b0;

    text_console_writer_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Screen predictor
    // ------------------------------------------------------------------
    function automatic void blank_cells(input int unsigned first);
        for (int unsigned i = first; i < CELLS; i++)
        begin
            glyph_mem[i] = BLANK_CHAR;
            attr_mem[i]  = color_reg;
        end
    endfunction

    function automatic void home_if_past_end();
        if (cursor_at >= CELLS)
        begin
            for (int unsigned i = 0; i < CELLS - COLUMNS; i++)
            begin
                glyph_mem[i] = glyph_mem[i + COLUMNS];
                attr_mem[i]  = attr_mem[i + COLUMNS];
            end
            blank_cells(CELLS - COLUMNS);
            cursor_at = (ROWS - 1) * COLUMNS + MARGIN;
        end
    endfunction

    function automatic void line_feed();
        cursor_at = (cursor_at / COLUMNS + 1) * COLUMNS + MARGIN;
        home_if_past_end();
    endfunction

    function automatic void write_char(input logic [CHAR_W-1:0] code);
        int unsigned col;
        home_if_past_end();
        if (code == CODE_NEWLINE)
        begin
            line_feed();
            return;
        end
        col = cursor_at % COLUMNS;
        if (code == CODE_BACKSPACE)
        begin
            // Backspace never steps into the margin.
            if (col > MARGIN && cursor_at > 0)
            begin
                cursor_at--;
                glyph_mem[cursor_at] = BLANK_CHAR;
                attr_mem[cursor_at]  = color_reg;
            end
            return;
        end
        if (code == eof_reg)
            return;
        if (col >= COLUMNS - 1)
            line_feed();
        if (cursor_at < CELLS)
        begin
            glyph_mem[cursor_at] = code;
            attr_mem[cursor_at]  = color_reg;
            cursor_at++;
        end
    endfunction

    function automatic console_reply_t console_step(input logic [FUNC_W-1:0] f,
                                                    input logic [CHAR_W-1:0] c,
                                                    input logic [X_W-1:0]    x,
                                                    input logic [Y_W-1:0]    y);
        console_reply_t r;
        int unsigned    pos;
        r = '0;
        case (f)
            FUNC_PUT:
                write_char(c);
            FUNC_SETCUR:
            begin
                pos       = x + MARGIN + y * COLUMNS;
                cursor_at = (pos > CELLS) ? CELLS : pos;
            end
            FUNC_CLEAR:
            begin
                blank_cells(0);
                cursor_at = MARGIN;
            end
            default:
            begin
                if (x < COLUMNS && y < ROWS)
                begin
                    pos     = y * COLUMNS + x;
                    r.glyph = glyph_mem[pos];
                    r.attr  = attr_mem[pos];
                end
            end
        endcase
        r.cursor = IDX_W'(cursor_at);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic issue_request(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                                 input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        char_code <= c;
        col_x     <= x;
        row_y     <= y;
        do
            @(posedge clk);
        while (in_stall);
        pending_replies.push_back(console_step(f, c, x, y));
        requests_sent++;
    endtask

    task automatic put_code(input logic [CHAR_W-1:0] c);
        issue_request(FUNC_PUT, c, X_W'($urandom()), Y_W'($urandom()));
    endtask

    task automatic move_cursor(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
        issue_request(FUNC_SETCUR, CHAR_W'($urandom()), x, y);
    endtask

    task automatic read_cell(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
        issue_request(FUNC_READ, CHAR_W'($urandom()), x, y);
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TEXT_COLOR)
            color_reg = data;
        else
            eof_reg = data;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------
    initial
    begin : result_stall
        int unsigned wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles != 0)
            begin
                wait_cycles = hold_cycles;
                hold_cycles = 0;
            end
            else
                wait_cycles = receiver_calm ? 0 : $urandom_range(0, 9);
            if (wait_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : reply_checker
        console_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: char %02h color %02h cursor %0d",
                             cell_char, cell_color, cursor_index);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (cell_char !== want.glyph || cell_color !== want.attr ||
                    cursor_index !== want.cursor)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected char %02h color %02h cursor %0d,",
                                  " got char %02h color %02h cursor %0d"},
                                 want.glyph, want.attr, want.cursor,
                                 cell_char, cell_color, cursor_index);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("FAIL text_console_writer_core");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_contents();
        read_cell(X_W'(0), Y_W'(0));
        read_cell(X_W'(COLUMNS - 1), Y_W'(ROWS - 1));
        read_cell(7'h7F, 5'h1F);
    endtask

    task automatic test_put_and_backspace();
        put_code(8'h48);
        put_code(8'h00);
        // The third backspace finds the cursor at the margin and must not move.
        repeat (3) put_code(CODE_BACKSPACE);
        put_code(CODE_NEWLINE);
        read_cell(X_W'(1), Y_W'(0));
    endtask

    task automatic test_wrap_and_scroll();
        move_cursor(X_W'(COLUMNS - 2), Y_W'(0));
        put_code(8'h57);
        // The last column plus the margin lands at column zero of the next row.
        move_cursor(X_W'(COLUMNS - 1), Y_W'(0));
        put_code(CODE_BACKSPACE);
        put_code(8'h78);
        move_cursor(7'h7F, 5'h1F);
        put_code(8'h53);
        move_cursor(X_W'(0), Y_W'(ROWS - 1));
        put_code(CODE_NEWLINE);
        read_cell(X_W'(1), Y_W'(ROWS - 3));
    endtask

    task automatic test_eof_code();
        write_reg(REG_EOF_CODE, 8'h51);
        put_code(8'h51);
        // Newline and backspace win over a matching ignored code.
        write_reg(REG_EOF_CODE, CODE_NEWLINE);
        put_code(CODE_NEWLINE);
        write_reg(REG_EOF_CODE, CODE_BACKSPACE);
        put_code(CODE_BACKSPACE);
        write_reg(REG_EOF_CODE, 8'h00);
        put_code(8'h00);
    endtask

    task automatic test_text_color();
        write_reg(REG_TEXT_COLOR, 8'h00);
        put_code(8'h63);
        write_reg(REG_TEXT_COLOR, 8'hFF);
        issue_request(FUNC_CLEAR, CHAR_W'($urandom()), X_W'($urandom()), Y_W'($urandom()));
        read_cell(X_W'(COLUMNS / 2), Y_W'(ROWS / 2));
    endtask

    task automatic test_backpressure();
        wait_until_idle();
        hold_cycles = LONG_HOLD;
        sender_calm = 1'b1;
        repeat (40) put_code(CHAR_W'($urandom_range(8'h21, 8'h7E)));
        sender_calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned stop_at;
        int unsigned kind;
        int unsigned row;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_TEXT_COLOR, 8'h00);
                    write_reg(REG_EOF_CODE, 8'h00);
                end
                1:
                begin
                    write_reg(REG_TEXT_COLOR, 8'hFF);
                    write_reg(REG_EOF_CODE, EOF_RESET);
                end
                default:
                begin
                    write_reg(REG_TEXT_COLOR, COLOR_W'($urandom_range(0, 255)));
                    write_reg(REG_EOF_CODE, COLOR_W'($urandom_range(0, 255)));
                end
            endcase
            sender_calm   = (phase == 2);
            receiver_calm = (phase == 2 || phase == 4);
            stop_at = requests_sent + PHASE_ITEMS;
            while (requests_sent < stop_at)
            begin
                kind = $urandom_range(0, 99);
                row  = $urandom_range(0, ROWS - 1);
                if (kind < 45)
                begin
                    // A line of text with the odd edit, usually closed by newline.
                    move_cursor(X_W'($urandom_range(0, COLUMNS - 1)), Y_W'(row));
                    repeat ($urandom_range(1, 24))
                    begin
                        case ($urandom_range(0, 9))
                            0:       put_code(CODE_BACKSPACE);
                            1:       put_code(CHAR_W'($urandom_range(0, 255)));
                            default: put_code(CHAR_W'($urandom_range(8'h21, 8'h7E)));
                        endcase
                    end
                    if ($urandom_range(0, 2) != 0)
                        put_code(CODE_NEWLINE);
                end
                else if (kind < 60)
                begin
                    // Read back around the row the cursor is on.
                    row = cursor_at / COLUMNS;
                    if (row >= ROWS)
                        row = ROWS - 1;
                    repeat ($urandom_range(1, 4))
                        read_cell(X_W'($urandom_range(0, COLUMNS - 1)), Y_W'(row));
                end
                else if (kind < 72)
                begin
                    move_cursor(X_W'($urandom_range(COLUMNS - 12, COLUMNS - 2)), Y_W'(row));
                    repeat ($urandom_range(1, 12))
                        put_code(CHAR_W'($urandom_range(8'h21, 8'h7E)));
                    read_cell(X_W'($urandom_range(0, COLUMNS - 1)), Y_W'((row + 1) % ROWS));
                end
                else if (kind < 82)
                begin
                    move_cursor(X_W'($urandom_range(0, 127)), Y_W'($urandom_range(ROWS - 1, 31)));
                    repeat ($urandom_range(1, 4))
                        put_code(CHAR_W'($urandom_range(0, 3) == 0 ? CODE_NEWLINE
                                                                   : $urandom_range(8'h21, 8'h7E)));
                end
                else if (kind < 90)
                begin
                    move_cursor(X_W'($urandom_range(0, 6)), Y_W'(row));
                    repeat ($urandom_range(1, 10))
                        put_code(CODE_BACKSPACE);
                end
                else
                begin
                    repeat ($urandom_range(1, 3))
                        issue_request(FUNC_W'($urandom_range(0, 3)),
                                      CHAR_W'($urandom_range(0, 255)),
                                      X_W'($urandom_range(0, 127)),
                                      Y_W'($urandom_range(0, 31)));
                end
            end
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
    endtask

    initial
    begin
        color_reg = RESET_COLOR;
        eof_reg   = EOF_RESET;
        blank_cells(0);
        cursor_at = MARGIN;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_put_and_backspace();
        test_wrap_and_scroll();
        test_eof_code();
        test_text_color();
        test_backpressure();
        test_random_traffic();

        wait_until_idle();
        if (mismatches == 0)
            $display("PASS text_console_writer_core");
        else
            $display("FAIL text_console_writer_core");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer_core.sv
tb/text_console_writer_core_test.sv
